/* sv/gdfw_pkg.sv */
// ----------------------------------------------------------------------------
// gdfw_pkg: shared types and constants for the depth-first walk block
// Item codes, status codes, register indexes, sequencer states and the
// control groups that pass between the sequencer and its storage units.
// ----------------------------------------------------------------------------
package gdfw_pkg;

   localparam int VTX_FIELD_W = 4;
   localparam int STATUS_W    = 2;
   localparam int VCOUNT_W    = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;
   localparam int                  VTX_LIMIT    = 16;

   // register word index (byte address / 4)
   localparam logic REG_VERTEX_COUNT = 1'b0;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_RUN = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OOR  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_CHECK,
      ST_EDGE,
      ST_FINAL,
      ST_STATUS
   } seq_state_type;

   typedef struct packed {
      logic add_en;
      logic rd_en;
   } edge_ctl_type;

   typedef struct packed {
      logic init;
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

/* sv/gdfw_edge_store.sv */
// ----------------------------------------------------------------------------
// gdfw_edge_store: adjacency lists of the graph
// Edge memory (target and link per edge), per-vertex list heads and the
// edge count. New edges go to the front of their source's list.
// ----------------------------------------------------------------------------
module gdfw_edge_store
   import gdfw_pkg::*;
#(
   parameter int VTX_USED  = 16,
   parameter int MAX_EDGES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  edge_ctl_type           ctl,
   input  logic [VTX_FIELD_W-1:0] lookup_vtx,
   input  logic [VTX_FIELD_W-1:0] add_dst,
   input  logic [$clog2(MAX_EDGES+1)-1:0] rd_addr,
   output logic [$clog2(MAX_EDGES+1)-1:0] head_link,
   output logic [$clog2(MAX_EDGES+1)-1:0] edge_total,
   output logic                   full,
   output logic [VTX_FIELD_W-1:0] rd_target,
   output logic [$clog2(MAX_EDGES+1)-1:0] rd_link
);

   localparam int LINK_W = $clog2(MAX_EDGES + 1);
   localparam int EA_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int VTX_W  = (VTX_USED > 1) ? $clog2(VTX_USED) : 1;
   localparam int ENT_W  = VTX_FIELD_W + LINK_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_EDGES);

   logic [ENT_W-1:0]  edge_mem [MAX_EDGES];
   logic [ENT_W-1:0]  rd_ff;
   logic [LINK_W-1:0] head_ff [VTX_USED];
   logic [LINK_W-1:0] total_ff;
   logic [LINK_W-1:0] total_in;
   logic [VTX_W-1:0]  lookup_idx;

   assign lookup_idx = lookup_vtx[VTX_W-1:0];
   assign head_link  = head_ff[lookup_idx];
   assign full       = (total_ff == NULL_LINK);
   assign edge_total = total_ff;
   assign total_in   = total_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int i = 0; i < VTX_USED; i++) begin
            head_ff[i] <= NULL_LINK;
         end
      end else if (ctl.add_en) begin
         total_ff            <= total_in;
         head_ff[lookup_idx] <= total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.add_en) begin
         edge_mem[total_ff[EA_W-1:0]] <= {add_dst, head_ff[lookup_idx]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_ff <= edge_mem[rd_addr[EA_W-1:0]];
      end
   end

   assign rd_target = rd_ff[ENT_W-1:LINK_W];
   assign rd_link   = rd_ff[LINK_W-1:0];

endmodule

/* sv/gdfw_stack.sv */
// ----------------------------------------------------------------------------
// gdfw_stack: vertex stack of the walk
// Memory of vertex numbers with a depth counter; init restarts the stack
// with one vertex, pop returns the top vertex in the next cycle.
// ----------------------------------------------------------------------------
module gdfw_stack
   import gdfw_pkg::*;
#(
   parameter int MAX_EDGES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  stack_ctl_type          ctl,
   input  logic [VTX_FIELD_W-1:0] wr_data,
   output logic [VTX_FIELD_W-1:0] rd_data,
   output logic                   empty
);

   localparam int SLOTS = MAX_EDGES + 1;
   localparam int SA_W  = $clog2(SLOTS);
   localparam int SD_W  = $clog2(SLOTS + 1);

   logic [VTX_FIELD_W-1:0] stack_mem [SLOTS];
   logic [VTX_FIELD_W-1:0] rd_ff;
   logic [SD_W-1:0]        depth_ff;
   logic [SD_W-1:0]        depth_in;
   logic [SD_W-1:0]        depth_dec;
   logic                   room;
   logic                   wr_en;
   logic [SA_W-1:0]        wr_addr;

   assign depth_dec = depth_ff - 1'b1;
   assign room      = (depth_ff < SD_W'(SLOTS));
   assign empty     = (depth_ff == '0);
   assign wr_en     = ctl.init | (ctl.push & room);
   assign wr_addr   = ctl.init ? '0 : depth_ff[SA_W-1:0];

   always_comb begin
      depth_in = depth_ff;
      if (ctl.init) begin
         depth_in = SD_W'(1);
      end else if (ctl.push && room) begin
         depth_in = depth_ff + 1'b1;
      end else if (ctl.pop && !empty) begin
         depth_in = depth_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pop && !empty) begin
         rd_ff <= stack_mem[depth_dec[SA_W-1:0]];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* sv/gdfw_seq.sv */
// ----------------------------------------------------------------------------
// gdfw_seq: walk sequencer
// Takes add and run items, steps the stack and the edge lists one access a
// cycle, keeps the visited map and drives the result register. A visit is
// held back one step so that the final one can carry the last flag.
// ----------------------------------------------------------------------------
module gdfw_seq
   import gdfw_pkg::*;
#(
   parameter int VTX_USED  = 16,
   parameter int MAX_EDGES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [VTX_FIELD_W-1:0] req_from_vertex,
   input  logic [VTX_FIELD_W-1:0] req_to_vertex,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VTX_FIELD_W-1:0] rsp_visited_vertex,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_last,
   input  logic [VCOUNT_W-1:0]    live_count,
   output edge_ctl_type           edge_ctl,
   output logic [VTX_FIELD_W-1:0] lookup_vtx,
   output logic [$clog2(MAX_EDGES+1)-1:0] edge_rd_addr,
   input  logic [$clog2(MAX_EDGES+1)-1:0] head_link,
   input  logic [$clog2(MAX_EDGES+1)-1:0] edge_total,
   input  logic                   edge_full,
   input  logic [VTX_FIELD_W-1:0] edge_rd_target,
   input  logic [$clog2(MAX_EDGES+1)-1:0] edge_rd_link,
   output stack_ctl_type          stk_ctl,
   output logic [VTX_FIELD_W-1:0] stk_wr_data,
   input  logic [VTX_FIELD_W-1:0] stk_rd_data,
   input  logic                   stk_empty
);

   localparam int VTX_W = (VTX_USED > 1) ? $clog2(VTX_USED) : 1;

   seq_state_type state_ff, state_in;

   logic [VTX_USED-1:0]    seen_ff, seen_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [VTX_FIELD_W-1:0] pend_vtx_ff, pend_vtx_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VTX_FIELD_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   from_oor;
   logic                   to_oor;
   logic                   out_free;
   logic                   pop_seen;
   logic                   head_live;
   logic                   link_live;
   logic                   nbr_new;
   logic [STATUS_W-1:0]    status_code;

   // output-side controls
   logic                   clear_seen;
   logic                   visit;
   logic                   emit;
   logic [VTX_FIELD_W-1:0] emit_vtx;
   logic [STATUS_W-1:0]    emit_status;
   logic                   emit_last;
   logic                   status_load;

   assign from_oor  = ({1'b0, req_from_vertex} >= live_count);
   assign to_oor    = ({1'b0, req_to_vertex} >= live_count);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop_seen  = seen_ff[stk_rd_data[VTX_W-1:0]];
   assign head_live = (head_link < edge_total);
   assign link_live = (edge_rd_link < edge_total);
   assign nbr_new   = ({1'b0, edge_rd_target} < live_count)
                      && !seen_ff[edge_rd_target[VTX_W-1:0]];
   assign lookup_vtx  = (state_ff == ST_IDLE) ? req_from_vertex : stk_rd_data;
   assign stk_wr_data = (state_ff == ST_IDLE) ? req_from_vertex : edge_rd_target;
   assign req_stall   = (state_ff != ST_IDLE);

   always_comb begin
      if (from_oor || (req_mode == MODE_ADD && to_oor)) begin
         status_code = STATUS_OOR;
      end else if (req_mode == MODE_ADD && edge_full) begin
         status_code = STATUS_FULL;
      end else begin
         status_code = STATUS_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_RUN && !from_oor) begin
                  state_in = ST_POP;
               end else begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_POP: begin
            state_in = stk_empty ? ST_FINAL : ST_CHECK;
         end
         ST_CHECK: begin
            if (pop_seen) begin
               state_in = ST_POP;
            end else if (!pend_vld_ff || out_free) begin
               state_in = head_live ? ST_EDGE : ST_POP;
            end
         end
         ST_EDGE: begin
            state_in = link_live ? ST_EDGE : ST_POP;
         end
         ST_FINAL, ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      edge_ctl     = '0;
      stk_ctl      = '0;
      edge_rd_addr = head_link;
      clear_seen   = 1'b0;
      visit        = 1'b0;
      emit         = 1'b0;
      emit_vtx     = pend_vtx_ff;
      emit_status  = STATUS_OK;
      emit_last    = 1'b0;
      status_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            status_load     = req_valid;
            edge_ctl.add_en = req_valid && req_mode == MODE_ADD
                              && !from_oor && !to_oor && !edge_full;
            stk_ctl.init    = req_valid && req_mode == MODE_RUN && !from_oor;
            clear_seen      = stk_ctl.init;
         end
         ST_POP: begin
            stk_ctl.pop = !stk_empty;
         end
         ST_CHECK: begin
            // release the held visit before taking the new one
            visit          = !pop_seen && (!pend_vld_ff || out_free);
            emit           = visit && pend_vld_ff;
            edge_ctl.rd_en = visit && head_live;
         end
         ST_EDGE: begin
            stk_ctl.push   = nbr_new;
            edge_ctl.rd_en = link_live;
            edge_rd_addr   = edge_rd_link;
         end
         ST_FINAL: begin
            emit      = out_free;
            emit_last = 1'b1;
         end
         ST_STATUS: begin
            emit        = out_free;
            emit_vtx    = '0;
            emit_status = status_ff;
            emit_last   = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      seen_in     = seen_ff;
      pend_vld_in = pend_vld_ff;
      pend_vtx_in = pend_vtx_ff;
      status_in   = status_load ? status_code : status_ff;
      if (clear_seen) begin
         seen_in = '0;
      end else if (visit) begin
         seen_in[stk_rd_data[VTX_W-1:0]] = 1'b1;
      end
      if (visit) begin
         pend_vld_in = 1'b1;
         pend_vtx_in = stk_rd_data;
      end else if (state_ff == ST_FINAL && emit) begin
         pend_vld_in = 1'b0;
      end
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = emit_vtx;
         rsp_status_in = emit_status;
         rsp_last_in   = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_vtx_ff   <= pend_vtx_in;
      status_ff     <= status_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visited_vertex = rsp_vertex_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

   a_final_has_visit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |-> pend_vld_ff)
      else $error("walk ended without a held visit");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("held visit left over after an item");

   a_pending_is_seen: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> seen_ff[pend_vtx_ff[VTX_W-1:0]])
      else $error("held visit not marked in the visited map");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_last) |=> (state_ff == ST_IDLE))
      else $error("last result emitted but item still in progress");

endmodule

/* sv/graph_depth_first_walk.sv */
// ----------------------------------------------------------------------------
// graph_depth_first_walk: depth-first walk over a stored directed graph
// Add items store edges; run items emit the vertices reached from a start
// vertex in depth-first order, oldest edge of each list first.
//
//   channel  | ports                          | carries
//   ---------+--------------------------------+-------------------------------
//   req      | req_valid / req_stall          | mode, from_vertex, to_vertex
//   rsp      | rsp_valid / rsp_stall          | visited_vertex, status, last
//   csr      | csr_psel/penable/pwrite/paddr  | vertex_count at byte address 0
//
// Add item: accepted, then its result is emitted from the status state, and
// the next item is taken after that. Run item: pops the stack, checks the
// vertex, scans its edges and emits the last result from the final state.
// Each memory is accessed at most once a cycle. Synchronous reset empties
// the graph and sets vertex_count to 16; no clearing pass follows.
// req_stall is high while an item is in progress; a stalled result holds the walk at its next visit.
// ----------------------------------------------------------------------------
module graph_depth_first_walk
   import gdfw_pkg::*;
#(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EDGES    = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [VTX_FIELD_W-1:0] req_from_vertex,
   input  logic [VTX_FIELD_W-1:0] req_to_vertex,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VTX_FIELD_W-1:0] rsp_visited_vertex,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic                   rsp_last,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int VTX_USED = (MAX_VERTICES > VTX_LIMIT) ? VTX_LIMIT : MAX_VERTICES;
   localparam int LINK_W   = $clog2(MAX_EDGES + 1);

   logic [VCOUNT_W-1:0]    vcount_ff;
   logic [VCOUNT_W-1:0]    vcount_in;
   logic [VCOUNT_W-1:0]    live_count;
   logic                   csr_wr;

   edge_ctl_type           edge_ctl;
   stack_ctl_type          stk_ctl;
   logic [VTX_FIELD_W-1:0] lookup_vtx;
   logic [LINK_W-1:0]      edge_rd_addr;
   logic [LINK_W-1:0]      head_link;
   logic [LINK_W-1:0]      edge_total;
   logic                   edge_full;
   logic [VTX_FIELD_W-1:0] edge_rd_target;
   logic [LINK_W-1:0]      edge_rd_link;
   logic [VTX_FIELD_W-1:0] stk_wr_data;
   logic [VTX_FIELD_W-1:0] stk_rd_data;
   logic                   stk_empty;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_VERTEX_COUNT);
   assign vcount_in  = csr_wr ? csr_pwdata[VCOUNT_W-1:0] : vcount_ff;
   assign csr_prdata = (csr_paddr[2] == REG_VERTEX_COUNT)
                       ? {{(CSR_DATA_W-VCOUNT_W){1'b0}}, vcount_ff} : '0;

   // saturate at the number of vertices the store holds
   assign live_count = (vcount_ff > VCOUNT_W'(VTX_USED)) ? VCOUNT_W'(VTX_USED)
                                                          : vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else begin
         vcount_ff <= vcount_in;
      end
   end

   gdfw_edge_store #(
      .VTX_USED  (VTX_USED),
      .MAX_EDGES (MAX_EDGES)
   ) u_edge_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (edge_ctl),
      .lookup_vtx (lookup_vtx),
      .add_dst    (req_to_vertex),
      .rd_addr    (edge_rd_addr),
      .head_link  (head_link),
      .edge_total (edge_total),
      .full       (edge_full),
      .rd_target  (edge_rd_target),
      .rd_link    (edge_rd_link)
   );

   gdfw_stack #(
      .MAX_EDGES (MAX_EDGES)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stk_ctl),
      .wr_data (stk_wr_data),
      .rd_data (stk_rd_data),
      .empty   (stk_empty)
   );

   gdfw_seq #(
      .VTX_USED  (VTX_USED),
      .MAX_EDGES (MAX_EDGES)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_from_vertex    (req_from_vertex),
      .req_to_vertex      (req_to_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .live_count         (live_count),
      .edge_ctl           (edge_ctl),
      .lookup_vtx         (lookup_vtx),
      .edge_rd_addr       (edge_rd_addr),
      .head_link          (head_link),
      .edge_total         (edge_total),
      .edge_full          (edge_full),
      .edge_rd_target     (edge_rd_target),
      .edge_rd_link       (edge_rd_link),
      .stk_ctl            (stk_ctl),
      .stk_wr_data        (stk_wr_data),
      .stk_rd_data        (stk_rd_data),
      .stk_empty          (stk_empty)
   );

endmodule

/* tb/graph_depth_first_walk_test.sv */
// ----------------------------------------------------------------------------
// graph_depth_first_walk_test: self-checking bench for the depth-first walk
// Builds a graph through add items, runs walks from random start vertices
// and sweeps vertex_count over its extremes. A local graph predictor
// computes every status and visit order, and each result is compared
// field by field as it leaves the block, under random stalls in all but one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_depth_first_walk_test;
   import gdfw_pkg::*;

   localparam int VTX_SLOTS    = 16;
   localparam int EDGE_SLOTS   = 64;
   localparam int STACK_SLOTS  = EDGE_SLOTS + 1;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_ADDR_W-1:0] VCOUNT_ADDR =
      CSR_ADDR_W'({REG_VERTEX_COUNT, 2'b00});

   typedef struct packed {
      logic [VTX_FIELD_W-1:0] vertex;
      logic [STATUS_W-1:0]    status;
      logic                   last;
   } walk_result_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [VCOUNT_W-1:0]    count;
      logic                   mode;
      logic [VTX_FIELD_W-1:0] from_v;
      logic [VTX_FIELD_W-1:0] to_v;
      logic                   typed;
      logic [VTX_FIELD_W-1:0] vtx;
      logic [STATUS_W-1:0]    stat;
   } script_row_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = MODE_ADD;
   logic [VTX_FIELD_W-1:0] req_from_vertex = '0;
   logic [VTX_FIELD_W-1:0] req_to_vertex = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [VTX_FIELD_W-1:0] rsp_visited_vertex;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   rsp_last;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // graph predictor state
   logic [VTX_FIELD_W-1:0] edge_dst  [EDGE_SLOTS];
   logic [6:0]             edge_next [EDGE_SLOTS];
   logic [6:0]             adj_head  [VTX_SLOTS];
   int unsigned            edges_used = 0;
   logic [VCOUNT_W-1:0]    vcount_shadow = VCOUNT_RESET;

   walk_result_type fresh_q [$];
   walk_result_type visit_q [$];
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   bit           idle_on = 1'b1;

   script_row_type script [25] = '{
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd0,  4'd0,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd15, 4'd15, 1'b1, 4'd15, STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd0,  4'd15, 1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd15, 4'd0,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd0,  4'd1,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd0,  4'd2,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd1,  4'd3,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd2,  4'd3,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd3,  4'd0,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd5,  4'd5,  1'b1, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd0,  4'd7,  1'b0, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd5,  4'd0,  1'b0, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd3,  4'd15, 1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,  5'd4,  MODE_ADD, 4'd0,  4'd0,  1'b0, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd4,  4'd0,  1'b1, 4'd0,  STATUS_OOR},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd0,  4'd4,  1'b1, 4'd0,  STATUS_OOR},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd15, 4'd15, 1'b1, 4'd0,  STATUS_OOR},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd4,  4'd0,  1'b1, 4'd0,  STATUS_OOR},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd0,  4'd0,  1'b0, 4'd0,  STATUS_OK},
      '{ROW_CSR,  5'd0,  MODE_ADD, 4'd0,  4'd0,  1'b0, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_ADD, 4'd0,  4'd0,  1'b1, 4'd0,  STATUS_OOR},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd0,  4'd0,  1'b1, 4'd0,  STATUS_OOR},
      '{ROW_CSR,  5'd31, MODE_ADD, 4'd0,  4'd0,  1'b0, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd15, 4'd3,  1'b0, 4'd0,  STATUS_OK},
      '{ROW_ITEM, 5'd0,  MODE_RUN, 4'd3,  4'd9,  1'b0, 4'd0,  STATUS_OK}
   };

   logic [VCOUNT_W-1:0] phase_count [10] = '{
      5'd16, 5'd16, 5'd9, 5'd31, 5'd1, 5'd0, 5'd17, 5'd12, 5'd2, 5'd16
   };

   graph_depth_first_walk #(
      .MAX_VERTICES(VTX_SLOTS),
      .MAX_EDGES(EDGE_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_visited_vertex(rsp_visited_vertex),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = idle_on && ($urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      walk_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (visit_q.size() == 0) begin
            $error("unexpected result: vertex %0d status %0d last %0d",
                   rsp_visited_vertex, rsp_status, rsp_last);
            mismatch_count++;
         end else begin
            want = visit_q.pop_front();
            if (rsp_visited_vertex !== want.vertex) begin
               $error("visited_vertex: expected %0d, got %0d", want.vertex,
                      rsp_visited_vertex);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   function automatic int unsigned live_vertices(input logic [VCOUNT_W-1:0] c);
      return (c > VTX_SLOTS) ? VTX_SLOTS : c;
   endfunction

   // Compute the results of one item into fresh_q and update the graph.
   function automatic void graph_predict(input logic m,
                                         input logic [VTX_FIELD_W-1:0] f,
                                         input logic [VTX_FIELD_W-1:0] t);
      int unsigned            n;
      int unsigned            sp;
      int unsigned            e;
      logic [VTX_SLOTS-1:0]   seen;
      logic [VTX_FIELD_W-1:0] u;
      logic [VTX_FIELD_W-1:0] w;
      logic [VTX_FIELD_W-1:0] stk [STACK_SLOTS];
      walk_result_type        r;
      n = live_vertices(vcount_shadow);
      fresh_q.delete();
      r = '{vertex: '0, status: STATUS_OK, last: 1'b1};
      if (m == MODE_ADD) begin
         if (f >= n || t >= n) begin
            r.status = STATUS_OOR;
         end else if (edges_used >= EDGE_SLOTS) begin
            r.status = STATUS_FULL;
         end else begin
            // push at the front of the source's list
            edge_dst[edges_used]  = t;
            edge_next[edges_used] = adj_head[f];
            adj_head[f]           = 7'(edges_used);
            edges_used++;
         end
         fresh_q.push_back(r);
         return;
      end
      if (f >= n) begin
         r.status = STATUS_OOR;
         fresh_q.push_back(r);
         return;
      end
      seen   = '0;
      stk[0] = f;
      sp     = 1;
      while (sp > 0) begin
         sp--;
         u = stk[sp];
         if (seen[u]) continue;
         seen[u] = 1'b1;
         fresh_q.push_back(walk_result_type'{vertex: u, status: STATUS_OK,
                                             last: 1'b0});
         e = 32'(adj_head[u]);
         while (e < edges_used) begin
            w = edge_dst[e];
            // drop neighbors at or above the live count and full-stack pushes
            if (w < n && !seen[w] && sp < STACK_SLOTS) begin
               stk[sp] = w;
               sp++;
            end
            e = 32'(edge_next[e]);
         end
      end
      r = fresh_q.pop_back();
      r.last = 1'b1;
      fresh_q.push_back(r);
   endfunction

   task automatic send_item(input logic m, input logic [VTX_FIELD_W-1:0] f,
                            input logic [VTX_FIELD_W-1:0] t, input bit typed,
                            input walk_result_type typed_res);
      while (idle_on && $urandom_range(99) < 21) @(negedge clock);
      req_valid       = 1'b1;
      req_mode        = m;
      req_from_vertex = f;
      req_to_vertex   = t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      graph_predict(m, f, t);
      if (typed) visit_q.push_back(typed_res);
      else foreach (fresh_q[i]) visit_q.push_back(fresh_q[i]);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Hold the sender until every result is out and the block is idle.
   task automatic settle_block();
      while (visit_q.size() != 0 || req_stall) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_vertex_count(input logic [VCOUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] word;
      word              = $urandom();
      word[VCOUNT_W-1:0] = count;
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = VCOUNT_ADDR;
      csr_pwdata  = word;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      vcount_shadow = count;
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(count)) begin
         $error("vertex_count readback: expected %0d, got %0d", count, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic random_phase(input logic [VCOUNT_W-1:0] count, input int items);
      int unsigned            n;
      logic                   m;
      logic [VTX_FIELD_W-1:0] f;
      logic [VTX_FIELD_W-1:0] t;
      settle_block();
      write_vertex_count(count);
      n = live_vertices(count);
      repeat (items) begin
         m = ($urandom_range(99) < 40) ? MODE_RUN : MODE_ADD;
         f = VTX_FIELD_W'($urandom());
         t = VTX_FIELD_W'($urandom());
         // mostly in-range endpoints, the rest anything the fields allow
         if (n != 0 && $urandom_range(99) < 85) begin
            f = VTX_FIELD_W'($urandom_range(n - 1, 0));
            if (m == MODE_ADD) t = VTX_FIELD_W'($urandom_range(n - 1, 0));
         end
         send_item(m, f, t, 1'b0, '0);
      end
   endtask

   initial begin
      for (int i = 0; i < VTX_SLOTS; i++) adj_head[i] = 7'(EDGE_SLOTS);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            settle_block();
            write_vertex_count(script[i].count);
         end else begin
            send_item(script[i].mode, script[i].from_v, script[i].to_v,
                      script[i].typed,
                      '{vertex: script[i].vtx, status: script[i].stat, last: 1'b1});
         end
      end

      foreach (phase_count[p]) begin
         idle_on = (p != 1);
         random_phase(phase_count[p], 48);
      end
      idle_on = 1'b1;

      while (visit_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
